### rtl/core/wla_pkg.sv
// Shared constants, types and helpers of the windowed loss aggregator.
package wla_pkg;

  localparam int WLA_WINDOWS = 16;
  localparam int WLA_SOURCES = 8;
  localparam int SLOT_ID_W   = 8;
  localparam int DIV_W       = 80;
  localparam int PROD_W      = 78;
  localparam int BP_W        = 14;
  localparam logic [BP_W-1:0] BP_SCALE = 14'd10000;
  localparam logic [3:0] SEV_MAX = 4'd10;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW_WIDTH = 3'd0;
  localparam reg_idx_t REG_MAX_WINDOWS  = 3'd1;
  localparam reg_idx_t REG_MAX_OBS      = 3'd2;
  localparam reg_idx_t REG_MAX_SOURCES  = 3'd3;
  localparam reg_idx_t REG_MAX_EVIDENCE = 3'd4;

  localparam logic [39:0] RST_WINDOW_WIDTH = 40'd1000000000;
  localparam logic [4:0]  RST_MAX_WINDOWS  = 5'd16;
  localparam logic [31:0] RST_MAX_OBS      = 32'hFFFF_FFFF;
  localparam logic [3:0]  RST_MAX_SOURCES  = 4'd8;
  localparam logic [15:0] RST_MAX_EVIDENCE = 16'hFFFF;

  localparam int FL_SAT = 0;
  localparam int FL_SRC = 1;
  localparam int FL_EVI = 2;
  localparam int FL_RAT = 3;
  localparam int FL_OFK = 4;

  typedef struct packed {
    logic        valid;
    logic [63:0] index;
    logic [63:0] lost;
    logic [63:0] offered;
    logic [31:0] obs;
    logic [31:0] direct;
    logic [31:0] ratio;
    logic [8:0]  flags;
    logic [15:0] evid;
    logic [3:0]  nsrc_lo;
    logic        hit;
    logic        listed;
    logic        room;
  } wla_view_t;

  typedef struct packed {
    logic        inv;
    logic        init;
    logic        append;
    logic [63:0] index;
    logic [63:0] lost;
    logic [63:0] offered;
    logic [31:0] obs;
    logic [31:0] direct;
    logic [31:0] ratio;
    logic [8:0]  flags;
    logic [15:0] evid;
    logic [15:0] src;
  } wla_cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [63:0]          key;
    logic [SLOT_ID_W-1:0] id;
  } wla_min_t;

  function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

### rtl/core/wla_if.sv
// Input and result channel interfaces of the windowed loss aggregator.
interface wla_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] timestamp;
  logic [63:0]        lost_count;
  logic [63:0]        offered_count;
  logic               offered_flag;
  logic               direct_loss;
  logic [15:0]        source_id;
  logic [3:0]         loss_class;
  modport source(output valid, timestamp, lost_count, offered_count, offered_flag,
                 direct_loss, source_id, loss_class, input ready);
  modport sink(input valid, timestamp, lost_count, offered_count, offered_flag,
               direct_loss, source_id, loss_class, output ready);
endinterface

interface wla_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] win_index;
  logic [63:0]        lost_total;
  logic [63:0]        offered_total;
  logic [31:0]        loss_ratio;
  logic               ratio_set;
  logic [31:0]        observation_total;
  logic [3:0]         worst_severity;
  logic [3:0]         source_total;
  logic               saturated;
  logic               src_truncated;
  logic               evid_truncated;
  logic [63:0]        evictions_total;
  modport source(output valid, win_index, lost_total, offered_total, loss_ratio,
                 ratio_set, observation_total, worst_severity, source_total,
                 saturated, src_truncated, evid_truncated, evictions_total,
                 input ready);
  modport sink(input valid, win_index, lost_total, offered_total, loss_ratio,
               ratio_set, observation_total, worst_severity, source_total,
               saturated, src_truncated, evid_truncated, evictions_total,
               output ready);
endinterface

### rtl/core/wla_div.sv
// Restoring divider, one quotient bit per cycle.
module wla_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wla_pkg::DIV_W-1:0] dividend,
  input  logic [63:0]               divisor,
  output logic                      done,
  output logic [wla_pkg::DIV_W-1:0] quotient
);
  import wla_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r;
  logic [63:0]      rem_r;
  logic [63:0]      dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [64:0]      trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= 64'(trial - {1'b0, dvs_r});
        end else begin
          rem_r <= trial[63:0];
        end
        quo_r <= {quo_r[DIV_W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/wla_cell.sv
// One window slot with its source list and one stage of the minimum chain.
module wla_cell #(
  parameter int SOURCES = wla_pkg::WLA_SOURCES,
  parameter int CELL_ID = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sel,
  input  wla_pkg::wla_cmd_t  cmd,
  input  logic [3:0]         max_sources,
  input  wla_pkg::wla_min_t  prev,
  output wla_pkg::wla_view_t view,
  output wla_pkg::wla_min_t  min_out
);
  import wla_pkg::*;

  localparam int NS_W = $clog2(SOURCES + 1);
  localparam int CW   = (NS_W > 4) ? NS_W : 4;

  logic            valid_r;
  logic [63:0]     index_r;
  logic [63:0]     lost_r;
  logic [63:0]     offered_r;
  logic [31:0]     obs_r;
  logic [31:0]     direct_r;
  logic [31:0]     ratio_r;
  logic [8:0]      flags_r;
  logic [15:0]     evid_r;
  logic [NS_W-1:0] nsrc_r;
  logic [15:0]     src_r [SOURCES];
  wla_min_t        min_r;
  logic [NS_W-1:0] base;
  logic [CW-1:0]   scap;
  logic            listed;
  logic            mine;

  assign base = cmd.init ? '0 : nsrc_r;
  assign scap = (CW'(max_sources) > CW'(SOURCES)) ? CW'(SOURCES) : CW'(max_sources);
  assign mine = valid_r && (!prev.valid || key_less(index_r, prev.key));

  always_comb begin
    listed = 1'b0;
    for (int k = 0; k < SOURCES; k++) begin
      if ((NS_W'(k) < nsrc_r) && (src_r[k] == cmd.src)) listed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      min_r.valid <= 1'b0;
    end else begin
      min_r.valid <= mine || prev.valid;
      min_r.key   <= mine ? index_r : prev.key;
      min_r.id    <= mine ? SLOT_ID_W'(CELL_ID) : prev.id;
      if (sel) begin
        if (cmd.inv) begin
          valid_r <= 1'b0;
        end else begin
          valid_r   <= 1'b1;
          index_r   <= cmd.index;
          lost_r    <= cmd.lost;
          offered_r <= cmd.offered;
          obs_r     <= cmd.obs;
          direct_r  <= cmd.direct;
          ratio_r   <= cmd.ratio;
          flags_r   <= cmd.flags;
          evid_r    <= cmd.evid;
          nsrc_r    <= base + NS_W'(cmd.append);
          for (int k = 0; k < SOURCES; k++) begin
            if (cmd.append && (base == NS_W'(k))) src_r[k] <= cmd.src;
          end
        end
      end
    end
  end

  always_comb begin
    view.valid   = valid_r;
    view.index   = index_r;
    view.lost    = lost_r;
    view.offered = offered_r;
    view.obs     = obs_r;
    view.direct  = direct_r;
    view.ratio   = ratio_r;
    view.flags   = flags_r;
    view.evid    = evid_r;
    view.nsrc_lo = 4'(nsrc_r);
    view.hit     = valid_r && (index_r == cmd.index);
    view.listed  = listed;
    view.room    = CW'(nsrc_r) < scap;
  end

  assign min_out = min_r;

endmodule

### rtl/core/windowed_loss_aggregator_top.sv
// Top level of the windowed loss aggregator: config port, sequencer and row of window cells.
// One observation at a time: the shared divider computes the window index, a lookup step follows,
// then shift-add forms lost*10000 and the divider computes the basis-point ratio; the last steps
// place the window, check the limit and report. A full table waits for the registered minimum
// chain to settle before a replacement, and every eviction waits for it likewise. Results sit in
// an output register while the next observation is accepted; a held result stalls only the end
// of the next one. Configuration is to be written through the APB port while idle; the block
// itself does not enforce this.
module windowed_loss_aggregator_top #(
  parameter int WINDOWS = wla_pkg::WLA_WINDOWS,
  parameter int SOURCES = wla_pkg::WLA_SOURCES
) (
  input  logic        clk,
  input  logic        rst_n,
  wla_in_if.sink      in_bus,
  wla_out_if.source   out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import wla_pkg::*;

  localparam int CNT_W  = $clog2(WINDOWS + 1);
  localparam int WAIT_N = WINDOWS + 2;
  localparam int WT_W   = $clog2(WAIT_N + 1);
  localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_IDX, S_LOOK, S_MUL, S_DIV_RAT, S_PLACE, S_WAIT, S_REPLACE,
    S_TRIM, S_EVICT, S_DONE
  } state_t;

  state_t          state_r;
  state_t          ret_r;
  logic [39:0]     ww_r;
  logic [4:0]      mw_r;
  logic [31:0]     mo_r;
  logic [3:0]      ms_r;
  logic [15:0]     me_r;
  logic [63:0]     in_lost_r;
  logic [63:0]     in_offered_r;
  logic            in_ofk_r;
  logic            in_dl_r;
  logic [3:0]      in_class_r;
  logic            neg_r;
  wla_cmd_t        cmd_r;
  logic [WINDOWS-1:0] sel_r;
  logic [WINDOWS-1:0] hitv_r;
  logic [WINDOWS-1:0] freshv_r;
  logic            found_r;
  logic [CNT_W-1:0] cnt_r;
  logic [3:0]      nsrc_r;
  logic [PROD_W-1:0] prod_r;
  logic [3:0]      bit_r;
  logic [WT_W-1:0] wait_r;
  logic [63:0]     evict_r;
  logic            div_start_r;
  logic [DIV_W-1:0] div_a_r;
  logic [63:0]     div_b_r;
  logic            div_done;
  logic [DIV_W-1:0] div_q;

  logic            out_valid_r;
  logic [63:0]     o_index_r;
  logic [63:0]     o_lost_r;
  logic [63:0]     o_offered_r;
  logic [31:0]     o_ratio_r;
  logic [31:0]     o_obs_r;
  logic [3:0]      o_nsrc_r;
  logic [8:0]      o_flags_r;
  logic [63:0]     o_evict_r;

  wla_view_t       view [WINDOWS];
  wla_min_t        chain [WINDOWS+1];
  wla_min_t        min_tail;

  logic            cfg_wr;
  reg_idx_t        cfg_idx;
  logic [63:0]     w64;
  logic [63:0]     mag;
  logic [DIV_W-1:0] floor_a;
  wla_view_t       b;
  logic            found;
  logic [WINDOWS-1:0] hitv;
  logic [WINDOWS-1:0] freshv;
  logic [CNT_W-1:0] cnt;
  logic            listed;
  logic            room;
  logic [64:0]     lsum;
  logic [64:0]     osum;
  logic [3:0]      sev;
  logic [LIM_W-1:0] limit;
  logic [WINDOWS-1:0] minsel;
  logic            accept;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_WIDTH: cfg_prdata = {24'd0, ww_r};
      REG_MAX_WINDOWS:  cfg_prdata = {59'd0, mw_r};
      REG_MAX_OBS:      cfg_prdata = {32'd0, mo_r};
      REG_MAX_SOURCES:  cfg_prdata = {60'd0, ms_r};
      REG_MAX_EVIDENCE: cfg_prdata = {48'd0, me_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign accept       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  assign w64     = (ww_r == '0) ? 64'd1 : {24'd0, ww_r};
  assign mag     = 64'(-in_bus.timestamp);
  assign floor_a = in_bus.timestamp[63] ?
                   DIV_W'({16'd0, mag} + {16'd0, w64} - 80'd1) :
                   DIV_W'({16'd0, in_bus.timestamp});

  assign chain[0] = '0;
  assign min_tail = chain[WINDOWS];

  for (genvar k = 0; k < WINDOWS; k++) begin : g_cell
    wla_cell #(.SOURCES(SOURCES), .CELL_ID(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .sel(sel_r[k]), .cmd(cmd_r), .max_sources(ms_r),
      .prev(chain[k]), .view(view[k]), .min_out(chain[k+1])
    );
    assign hitv[k]   = view[k].hit;
    assign minsel[k] = (min_tail.id == SLOT_ID_W'(k));
  end

  always_comb begin
    b      = '0;
    freshv = '0;
    cnt    = '0;
    listed = 1'b0;
    room   = 1'b0;
    for (int k = 0; k < WINDOWS; k++) begin
      if (hitv[k]) begin
        b      = b | view[k];
        listed = listed | view[k].listed;
        room   = room | view[k].room;
      end
      if (view[k].valid) cnt = cnt + 1'b1;
      else if (freshv == '0) freshv[k] = 1'b1;
    end
    found = |hitv;
    if (!found) room = (ms_r != '0);
  end

  assign lsum  = {1'b0, b.lost} + {1'b0, in_lost_r};
  assign osum  = {1'b0, b.offered} + {1'b0, in_offered_r};
  assign sev   = (in_class_r > SEV_MAX) ? 4'd0 : in_class_r;
  assign limit = (LIM_W'(mw_r) < LIM_W'(WINDOWS)) ? LIM_W'(mw_r) : LIM_W'(WINDOWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ww_r <= RST_WINDOW_WIDTH;
      mw_r <= RST_MAX_WINDOWS;
      mo_r <= RST_MAX_OBS;
      ms_r <= RST_MAX_SOURCES;
      me_r <= RST_MAX_EVIDENCE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW_WIDTH: ww_r <= cfg_pwdata[39:0];
        REG_MAX_WINDOWS:  mw_r <= cfg_pwdata[4:0];
        REG_MAX_OBS:      mo_r <= cfg_pwdata[31:0];
        REG_MAX_SOURCES:  ms_r <= cfg_pwdata[3:0];
        REG_MAX_EVIDENCE: me_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      sel_r       <= '0;
      evict_r     <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= '0;
      div_start_r <= 1'b0;
      if ((state_r == S_DONE) && (!out_valid_r || out_bus.ready)) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            in_lost_r    <= in_bus.lost_count;
            in_offered_r <= in_bus.offered_count;
            in_ofk_r     <= in_bus.offered_flag;
            in_dl_r      <= in_bus.direct_loss;
            in_class_r   <= in_bus.loss_class;
            neg_r        <= in_bus.timestamp[63];
            cmd_r.src    <= in_bus.source_id;
            cmd_r.inv    <= 1'b0;
            div_a_r      <= floor_a;
            div_b_r      <= w64;
            div_start_r  <= 1'b1;
            state_r      <= S_DIV_IDX;
          end
        end
        S_DIV_IDX: begin
          if (div_done) begin
            cmd_r.index <= neg_r ? 64'(-div_q[63:0]) : div_q[63:0];
            state_r     <= S_LOOK;
          end
        end
        S_LOOK: begin
          hitv_r   <= hitv;
          freshv_r <= freshv;
          found_r  <= found;
          cnt_r    <= cnt;
          cmd_r.init    <= !found;
          cmd_r.append  <= !listed && room;
          cmd_r.lost    <= lsum[64] ? '1 : lsum[63:0];
          cmd_r.offered <= osum[64] ? '1 : osum[63:0];
          cmd_r.obs     <= (b.obs >= mo_r) ? b.obs : b.obs + 32'd1;
          cmd_r.direct  <= b.direct + 32'(in_dl_r);
          cmd_r.ratio   <= b.ratio;
          cmd_r.evid    <= (b.evid < me_r) ? b.evid + 16'd1 : b.evid;
          cmd_r.flags[FL_SAT] <= b.flags[FL_SAT] | lsum[64] | osum[64] | (b.obs >= mo_r);
          cmd_r.flags[FL_SRC] <= b.flags[FL_SRC] | (!listed && !room);
          cmd_r.flags[FL_EVI] <= b.flags[FL_EVI] | (b.evid >= me_r);
          cmd_r.flags[FL_RAT] <= b.flags[FL_RAT];
          cmd_r.flags[FL_OFK] <= b.flags[FL_OFK] | in_ofk_r;
          cmd_r.flags[8:5]    <= (sev > b.flags[8:5]) ? sev : b.flags[8:5];
          nsrc_r  <= b.nsrc_lo + 4'(!listed && room);
          prod_r  <= '0;
          bit_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (BP_SCALE[bit_r]) prod_r <= prod_r + (PROD_W'(cmd_r.lost) << bit_r);
          if (bit_r == 4'(BP_W - 1)) begin
            state_r <= S_DIV_RAT;
            ret_r   <= S_IDLE;
          end else begin
            bit_r <= bit_r + 4'd1;
          end
        end
        S_DIV_RAT: begin
          if (ret_r == S_IDLE) begin
            div_a_r     <= DIV_W'(prod_r);
            div_b_r     <= cmd_r.offered;
            div_start_r <= 1'b1;
            ret_r       <= S_DIV_RAT;
          end else if (div_done) begin
            if ((cmd_r.offered != '0) && (div_q[DIV_W-1:32] == '0)) begin
              cmd_r.ratio         <= div_q[31:0];
              cmd_r.flags[FL_RAT] <= 1'b1;
            end
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          priority if (found_r) begin
            sel_r   <= hitv_r;
            state_r <= S_TRIM;
          end else if (freshv_r != '0) begin
            sel_r   <= freshv_r;
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_TRIM;
          end else begin
            wait_r  <= '0;
            ret_r   <= S_REPLACE;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (wait_r == WT_W'(WAIT_N)) state_r <= ret_r;
          else wait_r <= wait_r + 1'b1;
        end
        S_REPLACE: begin
          evict_r <= evict_r + 64'd1;
          if (min_tail.valid && !key_less(cmd_r.index, min_tail.key)) sel_r <= minsel;
          state_r <= S_TRIM;
        end
        S_TRIM: begin
          cmd_r.inv <= 1'b0;
          if (LIM_W'(cnt_r) > limit) begin
            wait_r  <= '0;
            ret_r   <= S_EVICT;
            state_r <= S_WAIT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_EVICT: begin
          if (min_tail.valid) begin
            cmd_r.inv <= 1'b1;
            sel_r     <= minsel;
            cnt_r     <= cnt_r - 1'b1;
            evict_r   <= evict_r + 64'd1;
            state_r   <= S_TRIM;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_bus.ready) begin
            o_index_r   <= cmd_r.index;
            o_lost_r    <= cmd_r.lost;
            o_offered_r <= cmd_r.offered;
            o_ratio_r   <= cmd_r.ratio;
            o_obs_r     <= cmd_r.obs;
            o_nsrc_r    <= nsrc_r;
            o_flags_r   <= cmd_r.flags;
            o_evict_r   <= evict_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  wla_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(div_a_r),
    .divisor(div_b_r), .done(div_done), .quotient(div_q)
  );

  assign out_bus.valid             = out_valid_r;
  assign out_bus.win_index         = o_index_r;
  assign out_bus.lost_total        = o_lost_r;
  assign out_bus.offered_total     = o_offered_r;
  assign out_bus.loss_ratio        = o_ratio_r;
  assign out_bus.ratio_set         = o_flags_r[FL_RAT];
  assign out_bus.observation_total = o_obs_r;
  assign out_bus.worst_severity    = o_flags_r[8:5];
  assign out_bus.source_total      = o_nsrc_r;
  assign out_bus.saturated         = o_flags_r[FL_SAT];
  assign out_bus.src_truncated     = o_flags_r[FL_SRC];
  assign out_bus.evid_truncated    = o_flags_r[FL_EVI];
  assign out_bus.evictions_total   = o_evict_r;

endmodule
